/* design/ucs2u8_pkg.sv */
// Shared types, constants and the code-unit encoder for the UCS-2 to UTF-8 transcoder.
`timescale 1ns / 1ps

package ucs2u8_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW      = 8;
    localparam logic [CfgIdxW-1:0] REG_PLATFORM = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] REG_ENCODING = CfgIdxW'(1);

    // Platform and encoding codes that select transcoding
    localparam logic [15:0] PLATFORM_UNICODE = 16'd0;
    localparam logic [15:0] PLATFORM_WINDOWS = 16'd3;
    localparam logic [15:0] ENC_WIN_UCS2     = 16'd1;
    localparam logic [15:0] ENC_WIN_UCS4     = 16'd10;

    // UTF-8 range limits and lead/continuation marks
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [2:0]  LEAD2_MARK     = 3'b110;
    localparam logic [3:0]  LEAD3_MARK     = 4'b1110;
    localparam logic [1:0]  CONT_MARK      = 2'b10;

    // Up to three result bytes produced by one input transfer
    typedef struct packed {
        logic [2:0][7:0] bytes;  // bytes[0] goes out first
        logic [1:0]      cnt;    // 0 means no result
        logic            fin;
    } burst_t;

    // Encode one 16-bit code unit; surrogates are encoded as plain units
    function automatic burst_t encode_unit(logic [15:0] cp);
        burst_t b;
        b = '0;
        if (cp < ONE_BYTE_LIMIT) begin
            b.bytes[0] = cp[7:0];
            b.cnt      = 2'd1;
        end
        else if (cp < TWO_BYTE_LIMIT) begin
            b.bytes[0] = {LEAD2_MARK, cp[10:6]};
            b.bytes[1] = {CONT_MARK, cp[5:0]};
            b.cnt      = 2'd2;
        end
        else begin
            b.bytes[0] = {LEAD3_MARK, cp[15:12]};
            b.bytes[1] = {CONT_MARK, cp[11:6]};
            b.bytes[2] = {CONT_MARK, cp[5:0]};
            b.cnt      = 2'd3;
        end
        return b;
    endfunction

endpackage

/* design/ucs2u8_cfg.sv */
// Configuration registers and transcode mode decode.
`timescale 1ns / 1ps

module ucs2u8_cfg
    import ucs2u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               transcode
);

    logic [15:0] platform_reg;
    logic [15:0] encoding_reg;

    assign cfg_ready = 1'b1;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            platform_reg <= '0;
            encoding_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PLATFORM: platform_reg <= cfg_data;
                REG_ENCODING: encoding_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Unicode platform, or Windows platform with the UCS-2 or UCS-4 encoding
    assign transcode = (platform_reg == PLATFORM_UNICODE)
                    || ((platform_reg == PLATFORM_WINDOWS)
                        && ((encoding_reg == ENC_WIN_UCS2) || (encoding_reg == ENC_WIN_UCS4)));

endmodule

/* design/ucs2u8_pair.sv */
// Byte pairing state and per-transfer encoding into a result burst.
`timescale 1ns / 1ps

module ucs2u8_pair
    import ucs2u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       transcode,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output burst_t     burst
);

    logic [7:0] high_half_reg;
    logic [7:0] high_half_next;
    logic       pending_reg;
    logic       pending_next;

    // Pass through, hold a high half, or encode a complete unit
    always_comb
    begin
        burst          = '0;
        high_half_next = high_half_reg;
        pending_next   = 1'b0;
        if (!transcode)
        begin
            burst.bytes[0] = data_byte;
            burst.cnt      = 2'd1;
        end
        else if (!pending_reg)
        begin
            high_half_next = data_byte;
            pending_next   = !final_byte;
        end
        else
        begin
            burst = encode_unit({high_half_reg, data_byte});
        end
        burst.fin = final_byte;
    end

    // Advance pairing state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_half_reg <= '0;
            pending_reg   <= 1'b0;
        end
        else if (accept)
        begin
            high_half_reg <= high_half_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

/* design/ucs2u8_ser.sv */
// Result register that holds one burst and sends it out a byte at a time.
`timescale 1ns / 1ps

module ucs2u8_ser
    import ucs2u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       take_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    burst_t     burst_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       last_byte;
    logic       out_xfer;

    assign last_byte  = (idx_reg == (burst_reg.cnt - 2'd1));
    assign out_xfer   = busy_reg && out_ready;
    assign out_valid  = busy_reg;
    assign out_byte   = burst_reg.bytes[idx_reg];
    assign run_last   = last_byte;
    assign string_end = last_byte && burst_reg.fin;

    // Accept a new burst when empty or when the last byte leaves now
    assign take_ok = !busy_reg || (out_xfer && last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (out_xfer)
        begin
            if (last_byte)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Capture burst payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

endmodule

/* design/ucs2_to_utf8_transcoder_top.sv */
// Top level of the UCS-2 to UTF-8 transcoder with byte passthrough.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | data_byte, final_byte
//  out     | out_valid/out_ready  | out_byte, run_last, string_end
//
// One output byte per cycle from the result register while out_ready is high;
// an input byte yields zero to three output bytes.
// in_ready is high when the result register is empty or sends its last byte.
// Bytes that give no result still wait for a free result register.
// Reset clears the configuration registers and the pairing state.
// Output stalls hold the result register and its byte index.
`timescale 1ns / 1ps

module ucs2_to_utf8_transcoder_top
    import ucs2u8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               string_end
);

    logic   transcode;
    logic   in_xfer;
    logic   load;
    burst_t burst;

    assign in_xfer = in_valid && in_ready;
    assign load    = in_xfer && (burst.cnt != 2'd0);

    ucs2u8_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .transcode (transcode)
    );

    ucs2u8_pair u_pair (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_xfer),
        .transcode  (transcode),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .burst      (burst)
    );

    ucs2u8_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .burst      (burst),
        .take_ok    (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

/* design/ucs2u8_chk.sv */
// Port-level checker for the transcoder, bound to the top level.
`timescale 1ns / 1ps

module ucs2u8_chk
    import ucs2u8_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         data_byte,
    input logic               final_byte,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         out_byte,
    input logic               run_last,
    input logic               string_end
);

    // Stalled input transfer holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(final_byte))
        else $error("input changed while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
                                    && $stable(run_last) && $stable(string_end))
        else $error("result changed while stalled");

    // String end marks only the last byte of a run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // A byte that is not last in its run is a UTF-8 lead or continuation
    a_multi_hi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> out_byte[7])
        else $error("non-final byte of a run below 0x80");

    // After a non-final transfer, a continuation byte follows at once
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && (out_byte[7:6] == CONT_MARK))
        else $error("missing continuation byte");

endmodule

bind ucs2_to_utf8_transcoder_top ucs2u8_chk u_chk (.*);
